@@ sv/fmbq_pkg.sv @@
package fmbq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;

  // Operation codes on op_i
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_REAR   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_REAR    = 3'd5
  } op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIM,
    ST_POP_DATA,
    ST_MOVE_RD,
    ST_MOVE_WR,
    ST_DONE
  } state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;     // take a new operation
    logic prim;     // do the push or issue the pop read
    logic capture;  // latch popped data
    logic mv_rd;    // read the entry that rebalances the halves
    logic mv_wr;    // write it into the other half
  } ctrl_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic reject;       // full push, empty pop or unused code
    logic is_pop;
    logic need_move;    // rebalance planned for the current operation
    logic move_pending; // rebalance recorded at the primary step
  } dp_status_t;

endpackage

@@ sv/fmbq_ram.sv @@
module fmbq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 33
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/fmbq_datapath.sv @@
module fmbq_datapath import fmbq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctrl_cmd_t                cmd_i,
  output dp_status_t               status_o,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic signed [DATA_W-1:0] pop_value_o,
  output logic                     was_empty_o,
  output logic                     was_full_o
);

  // Each half is a ring; it may hold one extra entry before rebalancing
  localparam int unsigned HALF = (CAPACITY + 1) / 2 + 1;
  localparam int unsigned AW   = $clog2(HALF);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(HALF - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? AW'(HALF - 1) : p - 1'b1;
  endfunction

  op_e                     op_q;
  logic [DATA_W-1:0]       value_q;
  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           f_head_q, f_head_d, f_tail_q, f_tail_d;
  logic [AW-1:0]           b_head_q, b_head_d, b_tail_q, b_tail_d;
  logic                    move_q, mv_f2b_q, rd_side_q;
  logic signed [DATA_W-1:0] pop_value_q;
  logic                    was_empty_q, was_full_q;

  logic odd, full, empty, one;
  logic reject, is_push, is_pop, acc_b, acc_back, plan_move, plan_f2b;
  logic f_act, f_push, f_back, b_act, b_push, b_back;
  logic [DATA_W-1:0] wr_data, rd_data, f_rdata, b_rdata;
  logic [AW-1:0] f_addr, b_addr;

  assign odd   = count_q[0];
  assign full  = (count_q == CW'(CAPACITY));
  assign empty = (count_q == '0);
  assign one   = (count_q == CW'(1));

  // Plan the primary access and the rebalance; the front half holds floor(n/2)
  always_comb begin
    reject    = 1'b0;
    is_push   = 1'b0;
    is_pop    = 1'b0;
    acc_b     = 1'b0;
    acc_back  = 1'b0;
    plan_move = 1'b0;
    plan_f2b  = 1'b0;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        is_push   = 1'b1;
        reject    = full;
        plan_move = ~odd;
        plan_f2b  = 1'b1;
      end
      OP_PUSH_MIDDLE: begin
        is_push  = 1'b1;
        reject   = full;
        acc_b    = ~odd;
        acc_back = odd;
      end
      OP_PUSH_REAR: begin
        is_push   = 1'b1;
        reject    = full;
        acc_b     = 1'b1;
        acc_back  = 1'b1;
        plan_move = odd;
      end
      OP_POP_FRONT: begin
        is_pop    = 1'b1;
        reject    = empty;
        acc_b     = one;
        plan_move = odd & ~one;
      end
      OP_POP_MIDDLE: begin
        is_pop   = 1'b1;
        reject   = empty;
        acc_b    = odd;
        acc_back = ~odd;
      end
      OP_POP_REAR: begin
        is_pop    = 1'b1;
        reject    = empty;
        acc_b     = 1'b1;
        acc_back  = 1'b1;
        plan_move = ~odd;
        plan_f2b  = 1'b1;
      end
      default: begin
        reject = 1'b1;
      end
    endcase
  end

  assign rd_data = rd_side_q ? b_rdata : f_rdata;

  // Drive the ring accesses for the current command
  always_comb begin
    f_act   = 1'b0;
    f_push  = 1'b0;
    f_back  = 1'b0;
    b_act   = 1'b0;
    b_push  = 1'b0;
    b_back  = 1'b0;
    wr_data = value_q;
    if (cmd_i.prim && !reject) begin
      if (acc_b) begin
        b_act  = 1'b1;
        b_push = is_push;
        b_back = acc_back;
      end else begin
        f_act  = 1'b1;
        f_push = is_push;
        f_back = acc_back;
      end
    end
    if (cmd_i.mv_rd) begin
      if (mv_f2b_q) begin
        f_act  = 1'b1;
        f_back = 1'b1;
      end else begin
        b_act  = 1'b1;
      end
    end
    if (cmd_i.mv_wr) begin
      wr_data = rd_data;
      if (mv_f2b_q) begin
        b_act  = 1'b1;
        b_push = 1'b1;
      end else begin
        f_act  = 1'b1;
        f_push = 1'b1;
        f_back = 1'b1;
      end
    end
  end

  // Address and pointer update of each ring
  always_comb begin
    if (f_back) begin
      f_addr = f_push ? f_tail_q : ptr_dec(f_tail_q);
    end else begin
      f_addr = f_push ? ptr_dec(f_head_q) : f_head_q;
    end
    f_head_d = f_head_q;
    f_tail_d = f_tail_q;
    if (f_act && !f_back) f_head_d = f_push ? ptr_dec(f_head_q) : ptr_inc(f_head_q);
    if (f_act && f_back)  f_tail_d = f_push ? ptr_inc(f_tail_q) : ptr_dec(f_tail_q);

    if (b_back) begin
      b_addr = b_push ? b_tail_q : ptr_dec(b_tail_q);
    end else begin
      b_addr = b_push ? ptr_dec(b_head_q) : b_head_q;
    end
    b_head_d = b_head_q;
    b_tail_d = b_tail_q;
    if (b_act && !b_back) b_head_d = b_push ? ptr_dec(b_head_q) : ptr_inc(b_head_q);
    if (b_act && b_back)  b_tail_d = b_push ? ptr_inc(b_tail_q) : ptr_dec(b_tail_q);
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.prim && !reject) begin
      count_d = is_push ? count_q + 1'b1 : count_q - 1'b1;
    end
  end

  fmbq_ram #(.WIDTH(DATA_W), .DEPTH(HALF)) u_front_ram (
    .clk_i   (clk_i),
    .we_i    (f_act & f_push),
    .waddr_i (f_addr),
    .wdata_i (wr_data),
    .raddr_i (f_addr),
    .rdata_o (f_rdata)
  );

  fmbq_ram #(.WIDTH(DATA_W), .DEPTH(HALF)) u_back_ram (
    .clk_i   (clk_i),
    .we_i    (b_act & b_push),
    .waddr_i (b_addr),
    .wdata_i (wr_data),
    .raddr_i (b_addr),
    .rdata_o (b_rdata)
  );

  // Hold occupancy, ring pointers and the rebalance plan
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      f_head_q <= '0;
      f_tail_q <= '0;
      b_head_q <= '0;
      b_tail_q <= '0;
      move_q   <= 1'b0;
      mv_f2b_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      f_head_q <= f_head_d;
      f_tail_q <= f_tail_d;
      b_head_q <= b_head_d;
      b_tail_q <= b_tail_d;
      if (cmd_i.prim) begin
        move_q   <= plan_move & ~reject;
        mv_f2b_q <= plan_f2b;
      end
    end
  end

  // Latch the operation and build the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= op_e'(op_i);
      value_q     <= push_value_i;
      pop_value_q <= '0;
      was_empty_q <= 1'b0;
      was_full_q  <= 1'b0;
    end
    if (cmd_i.prim) begin
      rd_side_q <= acc_b;
      if (reject) begin
        was_full_q  <= is_push;
        was_empty_q <= is_pop;
        if (is_pop) pop_value_q <= '1;
      end
    end
    if (cmd_i.mv_rd) begin
      rd_side_q <= ~mv_f2b_q;
    end
    if (cmd_i.capture) begin
      pop_value_q <= rd_data;
    end
  end

  assign status_o.reject       = reject;
  assign status_o.is_pop       = is_pop;
  assign status_o.need_move    = plan_move;
  assign status_o.move_pending = move_q;

  assign pop_value_o = pop_value_q;
  assign was_empty_o = was_empty_q;
  assign was_full_o  = was_full_q;

  // Occupancy of each half, for the balance check
  logic [CW-1:0] f_size, b_size;
  assign f_size = CW'(f_tail_q) - CW'(f_head_q) + ((f_tail_q < f_head_q) ? CW'(HALF) : '0);
  assign b_size = CW'(b_tail_q) - CW'(b_head_q) + ((b_tail_q < b_head_q) ? CW'(HALF) : '0);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_count_only_prim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.prim |=> $stable(count_q))
    else $error("occupancy changed outside the primary step");

  a_halves_balanced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (f_size == (count_q >> 1)) && (b_size == count_q - (count_q >> 1)))
    else $error("front and back halves out of balance");

endmodule

@@ sv/fmbq_ctrl.sv @@
module fmbq_ctrl import fmbq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       result_valid_o
);

  state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_PRIM;
      end
      ST_PRIM: begin
        priority if (status_i.reject)    state_d = ST_DONE;
        else if (status_i.is_pop)        state_d = ST_POP_DATA;
        else if (status_i.need_move)     state_d = ST_MOVE_RD;
        else                             state_d = ST_DONE;
      end
      ST_POP_DATA: begin
        state_d = status_i.move_pending ? ST_MOVE_RD : ST_DONE;
      end
      ST_MOVE_RD: state_d = ST_MOVE_WR;
      ST_MOVE_WR: state_d = ST_DONE;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_PRIM:     cmd_o.prim    = 1'b1;
      ST_POP_DATA: cmd_o.capture = 1'b1;
      ST_MOVE_RD:  cmd_o.mv_rd   = 1'b1;
      ST_MOVE_WR:  cmd_o.mv_wr   = 1'b1;
      ST_DONE:     result_valid_o = 1'b1;
      default:     busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o && !result_valid_o)
    else $error("accepted transfer did not raise busy");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy_o)
    else $error("result strobe longer than one cycle");

  a_move_after_prim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mv_wr |-> $past(cmd_o.mv_rd))
    else $error("rebalance write without its read");

endmodule

@@ sv/front_middle_back_queue.sv @@
// Queue of signed 32-bit entries with push and pop at the front, the middle
// and the rear, holding up to CAPACITY entries. An operation is taken when
// start is high and busy is low; its result appears for exactly one cycle
// with result_valid_o high, and the receiver cannot stall it, so it must
// take the result in that cycle. The queue is kept as two ring buffers in
// RAM, the front half holding floor(n/2) entries, so every operation
// touches only ring ends. After it is taken, an operation passes through a
// primary step; a pop then captures its data, an operation that rebalances
// the halves then reads the moved entry from one half and writes it into
// the other, and a done step follows before the block returns to idle,
// where it can accept the next operation. The result strobe comes in the
// done step. The steps are set by the single registered read port of each
// half, used once for the pop and once for moving an entry between halves.
// A push when full is dropped with was_full_o set; a pop when empty
// returns -1 with was_empty_o set; unused op codes give an all-zero result
// and change nothing. No clearing pass is needed after reset.
module front_middle_back_queue import fmbq_pkg::*; #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          op_i,
  input  logic signed [DATA_W-1:0] push_value_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] pop_value_o,
  output logic                     was_empty_o,
  output logic                     was_full_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fmbq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  fmbq_datapath #(.CAPACITY(CAPACITY)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .op_i         (op_i),
    .push_value_i (push_value_i),
    .pop_value_o  (pop_value_o),
    .was_empty_o  (was_empty_o),
    .was_full_o   (was_full_o)
  );

endmodule
